@@ hdl/bsc_pkg.sv @@
`timescale 1ns / 1ps
package bsc_pkg;
   localparam int DIV_W      = 32;
   localparam int DIV_STAGES = DIV_W;
   localparam int SIDE_W     = 56;
   localparam int CSR_IDX_W  = 3;
   localparam int QUEUE_D    = 2;

   localparam logic [CSR_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_B1_B2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MC_MD   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OSS     = 3'd5;

   localparam logic [31:0] B6_OFFSET = 32'd4000;
   localparam logic [31:0] X3_BIAS   = 32'd32768;
   localparam logic [31:0] P_SCALE   = 32'd50000;
   localparam logic [31:0] P_C1      = 32'd3038;
   localparam logic [31:0] P_C2      = 32'hFFFF_E343;
   localparam logic [31:0] P_C3      = 32'd3791;
   localparam logic signed [31:0] T_MIN = -32'sd400;
   localparam logic signed [31:0] T_MAX = 32'sd850;
   localparam logic signed [31:0] P_MAX = 32'sd131071;

   typedef logic [SIDE_W-1:0] side_type;

   typedef struct packed {
      logic [31:0] ac1_ac2;
      logic [31:0] ac3_ac4;
      logic [31:0] ac5_ac6;
      logic [31:0] b1_b2;
      logic [31:0] mc_md;
      logic [1:0]  oss;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] prod;
      logic [18:0] up;
   } fq_type;

   function automatic logic [31:0] sx16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
      logic [63:0] f;
      f = {32'd0, a} * {32'd0, b};
      return f[31:0];
   endfunction
endpackage

@@ hdl/bsc_req_if.sv @@
`timescale 1ns / 1ps
interface bsc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_temp;
   logic [18:0] raw_press;
   modport source (output valid, output raw_temp, output raw_press, input ready);
   modport sink (input valid, input raw_temp, input raw_press, output ready);
endinterface

@@ hdl/bsc_rsp_if.sv @@
`timescale 1ns / 1ps
interface bsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] temp_tenths;
   logic [16:0] pressure_pa;
   logic        div_error;
   modport source (output valid, output temp_tenths, output pressure_pa,
                   output div_error, input ready);
   modport sink (input valid, input temp_tenths, input pressure_pa,
                 input div_error, output ready);
endinterface

@@ hdl/bsc_csr_if.sv @@
`timescale 1ns / 1ps
interface bsc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/bsc_front.sv @@
`timescale 1ns / 1ps
module bsc_front (
   input  logic            clock,
   input  logic            reset,
   bsc_req_if.sink         req_chan,
   input  bsc_pkg::cfg_type cfg,
   input  logic            pop,
   output bsc_pkg::fq_type head
);
   import bsc_pkg::*;

   logic [31:0] q_prod_ff [QUEUE_D];
   logic [18:0] q_up_ff   [QUEUE_D];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop_ok;
   logic signed [16:0] diff, ac5;
   logic signed [33:0] m34;

   assign req_chan.ready = (cnt_ff != 2'(QUEUE_D));
   assign push   = req_chan.valid && req_chan.ready;
   assign pop_ok = pop && (cnt_ff != 2'd0);

   always_comb begin
      diff = $signed({1'b0, req_chan.raw_temp}) - $signed({1'b0, cfg.ac5_ac6[15:0]});
      ac5  = $signed({1'b0, cfg.ac5_ac6[31:16]});
      m34  = diff * ac5;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_prod_ff[wr_ptr_ff] <= m34[31:0];
         q_up_ff[wr_ptr_ff]   <= req_chan.raw_press;
      end
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.prod  = q_prod_ff[rd_ptr_ff];
   assign head.up    = q_up_ff[rd_ptr_ff];
endmodule

@@ hdl/bsc_div.sv @@
`timescale 1ns / 1ps
module bsc_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [31:0]        num,
   input  logic [31:0]        den,
   input  bsc_pkg::side_type  side,
   output logic               out_valid,
   output logic [31:0]        quo,
   output bsc_pkg::side_type  side_o
);
   import bsc_pkg::*;

   logic        vld_ff  [DIV_STAGES];
   logic [31:0] rem_ff  [DIV_STAGES];
   logic [31:0] num_ff  [DIV_STAGES];
   logic [31:0] den_ff  [DIV_STAGES];
   logic [31:0] quo_ff  [DIV_STAGES];
   side_type    side_ff [DIV_STAGES];
   logic [31:0] rem_in  [DIV_STAGES];
   logic [31:0] quo_in  [DIV_STAGES];

   always_comb begin
      logic [31:0] r, n, d, q;
      logic [32:0] trial;
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            r = 32'd0; n = num; d = den; q = 32'd0;
         end else begin
            r = rem_ff[k-1]; n = num_ff[k-1]; d = den_ff[k-1]; q = quo_ff[k-1];
         end
         trial = {r, n[31]} - {1'b0, d};
         if (!trial[32]) begin
            rem_in[k] = trial[31:0];
            quo_in[k] = {q[30:0], 1'b1};
         end else begin
            rem_in[k] = {r[30:0], n[31]};
            quo_in[k] = {q[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < DIV_STAGES; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
         num_ff[0]  <= {num[30:0], 1'b0};
         den_ff[0]  <= den;
         side_ff[0] <= side;
         for (int k = 1; k < DIV_STAGES; k++) begin
            num_ff[k]  <= {num_ff[k-1][30:0], 1'b0};
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign quo       = quo_ff[DIV_STAGES-1];
   assign side_o    = side_ff[DIV_STAGES-1];
endmodule

@@ hdl/bsc_back.sv @@
`timescale 1ns / 1ps
module bsc_back (
   input  logic             clock,
   input  logic             reset,
   input  bsc_pkg::cfg_type cfg,
   input  bsc_pkg::fq_type  head,
   output logic             pop,
   bsc_rsp_if.source        rsp_chan
);
   import bsc_pkg::*;

   logic        adv;
   logic        rsp_valid_ff;
   logic [10:0] rsp_temp_ff;
   logic [16:0] rsp_press_ff;
   logic        rsp_err_ff;

   // first divider
   logic [31:0] x1_0, den_0, num_0, nmag_0, dmag_0;
   side_type    d1_side, d1_side_o;
   logic        d1_vo;
   logic [31:0] d1_q;

   logic        v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic [31:0] b5_ff, x2_1;
   logic [18:0] up1_ff, up2_ff, up3_ff, up4_ff;
   logic        dz1_ff, dz2_ff, dz3_ff, dz4_ff, dz5_ff;
   logic [31:0] b6_ff, sqp_ff, t_2, b6_2;
   logic [10:0] ts2_ff, ts3_ff, ts4_ff, ts5_ff, ts6_ff, ts7_ff, ts_in;
   logic [31:0] p1_ff, p2_ff, p3_ff, p4_ff, sq_3;
   logic [31:0] b3_ff, t3_ff, x3a_4, x3b_4, s_4;
   logic [16:0] b4_ff;
   logic [31:0] b7_ff, b4m_5;
   side_type    d2_side, d2_side_o;
   logic        d2_vo;
   logic [31:0] d2_q, pu_6, pa_ff, pb_ff, p6_ff, ph_6;
   logic        err6_ff, err7_ff;
   logic [31:0] x1_7_ff, x2_7_ff, p7_ff;
   logic [31:0] pc_8, pf_8;
   logic [16:0] press_in;

   assign adv = !rsp_valid_ff || rsp_chan.ready;
   assign pop = adv;

   always_comb begin
      x1_0   = $signed(head.prod) >>> 15;
      den_0  = x1_0 + sx16(cfg.mc_md[15:0]);
      num_0  = sx16(cfg.mc_md[31:16]) << 11;
      nmag_0 = num_0[31] ? (32'd0 - num_0) : num_0;
      dmag_0 = den_0[31] ? (32'd0 - den_0) : den_0;
      d1_side = {3'd0, x1_0, head.up, (den_0 == 32'd0), num_0[31] ^ den_0[31]};
   end

   bsc_div u_div_t (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(head.valid),
      .num(nmag_0), .den(dmag_0), .side(d1_side),
      .out_valid(d1_vo), .quo(d1_q), .side_o(d1_side_o)
   );

   always_comb begin
      x2_1 = d1_side_o[0] ? (32'd0 - d1_q) : d1_q;
      t_2  = $signed(b5_ff + 32'd8) >>> 4;
      b6_2 = b5_ff - B6_OFFSET;
      if ($signed(t_2) < T_MIN) ts_in = T_MIN[10:0];
      else if ($signed(t_2) > T_MAX) ts_in = T_MAX[10:0];
      else ts_in = t_2[10:0];
      sq_3  = $signed(sqp_ff) >>> 12;
      x3a_4 = ($signed(p1_ff) >>> 11) + ($signed(p2_ff) >>> 11);
      s_4   = ((sx16(cfg.ac1_ac2[31:16]) << 2) + x3a_4) << cfg.oss;
      x3b_4 = (($signed(p3_ff) >>> 13) + ($signed(p4_ff) >>> 16) + 32'sd2) >>> 2;
      b4m_5 = mul32({16'd0, cfg.ac3_ac4[15:0]}, t3_ff);
      d2_side = {42'd0, ts5_ff, dz5_ff, (b4_ff == 17'd0), b7_ff[31]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; v7_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= d1_vo; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         v5_ff <= v4_ff; v6_ff <= d2_vo; v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b5_ff  <= d1_side_o[52:21] + x2_1;
         up1_ff <= d1_side_o[20:2];
         dz1_ff <= d1_side_o[1];

         b6_ff  <= b6_2;
         sqp_ff <= mul32(b6_2, b6_2);
         ts2_ff <= ts_in;
         up2_ff <= up1_ff;
         dz2_ff <= dz1_ff;

         p1_ff  <= mul32(sx16(cfg.b1_b2[15:0]), sq_3);
         p2_ff  <= mul32(sx16(cfg.ac1_ac2[15:0]), b6_ff);
         p3_ff  <= mul32(sx16(cfg.ac3_ac4[31:16]), b6_ff);
         p4_ff  <= mul32(sx16(cfg.b1_b2[31:16]), sq_3);
         ts3_ff <= ts2_ff;
         up3_ff <= up2_ff;
         dz3_ff <= dz2_ff;

         b3_ff  <= $signed(s_4 + 32'd2) >>> 2;
         t3_ff  <= x3b_4 + X3_BIAS;
         ts4_ff <= ts3_ff;
         up4_ff <= up3_ff;
         dz4_ff <= dz3_ff;

         b4_ff  <= b4m_5[31:15];
         b7_ff  <= mul32({13'd0, up4_ff} - b3_ff, P_SCALE >> cfg.oss);
         ts5_ff <= ts4_ff;
         dz5_ff <= dz4_ff;

         p6_ff   <= pu_6;
         pa_ff   <= mul32(ph_6, ph_6);
         pb_ff   <= mul32(P_C2, pu_6);
         ts6_ff  <= d2_side_o[13:3];
         err6_ff <= d2_side_o[2] | d2_side_o[1];

         x1_7_ff <= $signed(mul32(pa_ff, P_C1)) >>> 16;
         x2_7_ff <= $signed(pb_ff) >>> 16;
         p7_ff   <= p6_ff;
         ts7_ff  <= ts6_ff;
         err7_ff <= err6_ff;
      end
   end

   bsc_div u_div_p (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(v5_ff),
      .num(b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0}), .den({15'd0, b4_ff}),
      .side(d2_side), .out_valid(d2_vo), .quo(d2_q), .side_o(d2_side_o)
   );

   always_comb begin
      pu_6 = d2_side_o[0] ? {d2_q[30:0], 1'b0} : d2_q;
      ph_6 = $signed(pu_6) >>> 8;
      pc_8 = $signed(x1_7_ff + x2_7_ff + P_C3) >>> 4;
      pf_8 = p7_ff + pc_8;
      if (pf_8[31]) press_in = 17'd0;
      else if ($signed(pf_8) > P_MAX) press_in = P_MAX[16:0];
      else press_in = pf_8[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= v7_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_err_ff   <= err7_ff;
         rsp_temp_ff  <= err7_ff ? 11'd0 : ts7_ff;
         rsp_press_ff <= err7_ff ? 17'd0 : press_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.temp_tenths = rsp_temp_ff;
   assign rsp_chan.pressure_pa = rsp_press_ff;
   assign rsp_chan.div_error   = rsp_err_ff;
endmodule

@@ hdl/baro_sensor_compensation.sv @@
`timescale 1ns / 1ps
// Barometric sensor compensation. Takes one raw temperature/pressure beat per
// cycle unless the response side stalls, and returns temperature in tenths of
// a degree and pressure in pascals, both saturated, with div_error set (and
// both results zero) when a divisor is zero. The back end holds two 32-stage
// restoring divider pipelines. A two-beat queue parts the input side from the
// back-end pipeline. The user must write calibration registers only while the
// block is empty; the block itself does not enforce this.
module baro_sensor_compensation (
   input  logic       clock,
   input  logic       reset,
   bsc_req_if.sink    req_chan,
   bsc_rsp_if.source  rsp_chan,
   bsc_csr_if.sink    csr_chan
);
   import bsc_pkg::*;

   cfg_type cfg_ff;
   fq_type  head;
   logic    pop;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            REG_AC1_AC2: cfg_ff.ac1_ac2 <= csr_chan.data;
            REG_AC3_AC4: cfg_ff.ac3_ac4 <= csr_chan.data;
            REG_AC5_AC6: cfg_ff.ac5_ac6 <= csr_chan.data;
            REG_B1_B2:   cfg_ff.b1_b2   <= csr_chan.data;
            REG_MC_MD:   cfg_ff.mc_md   <= csr_chan.data;
            REG_OSS:     cfg_ff.oss     <= csr_chan.data[1:0];
            default: ;
         endcase
      end
   end

   bsc_front u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan), .cfg(cfg_ff),
      .pop(pop), .head(head)
   );

   bsc_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .head(head), .pop(pop),
      .rsp_chan(rsp_chan)
   );

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.div_error |->
         rsp_chan.temp_tenths == 11'd0 && rsp_chan.pressure_pa == 17'd0)
      else $error("error beat carries non-zero results");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> $signed(rsp_chan.temp_tenths) >= -11'sd400 &&
                         $signed(rsp_chan.temp_tenths) <= 11'sd850)
      else $error("temperature outside saturation range");
endmodule
